// ===== hw/rtl/fbpa_pkg.sv =====
// Shared types, constants and command/status structs for the block pool allocator.
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int unsigned POOL_DEPTH      = 256;
  localparam int unsigned HEADER_BYTES    = 32;
  localparam int unsigned MIN_BLOCK_BYTES = 16;

  localparam int unsigned PTR_W  = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W  = PTR_W + 1;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BSZ_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]  POOL_CNT_MAX = CNT_W'(POOL_DEPTH);
  localparam logic [ADDR_W-1:0] HEADER_OFS   = ADDR_W'(HEADER_BYTES);
  localparam logic [BSZ_W-1:0]  MIN_BSZ      = BSZ_W'(MIN_BLOCK_BYTES);
  localparam logic [BSZ_W-1:0]  BSZ_RESET    = BSZ_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_BLOCK_COUNT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_GRANT
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    fill_start;
    logic    fill_step;
    logic    fill_done;
    logic    alloc_read;
    logic    alloc_pop;
    logic    free_push;
    logic    res_load;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  init_bad;
    logic  pool_valid;
    logic  empty;
    logic  full;
    logic  addr_zero;
    logic  fill_last;
  } sts_t;

endpackage

// ===== hw/rtl/fixed_block_pool_allocator_top.sv =====
// Top level of the fixed-size block pool allocator with a FIFO free list.
//
//  Channel   | Handshake                | Payload
//  ----------+--------------------------+-------------------------------------------
//  request   | start_i, busy_o          | mode_i, block_address_i
//  result    | done_o (one-cycle pulse) | status_o, granted_address_o, pool_valid_o,
//            |                          | free_count_o
//  settings  | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// A request is taken when start_i is high and busy_o is low. Free and rejected
// requests end in S_EXEC; a good alloc adds S_GRANT (registered read of the free-list
// memory), a good init adds S_FILL (one memory write per block on the single write port).
// The result pulse comes in the cycle busy_o drops, so a new request can be taken
// alongside it. Reset empties the list and clears the valid mark; memory contents
// are not cleared. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
module fixed_block_pool_allocator_top import fbpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           mode_i,
  input  logic [ADDR_W-1:0]    block_address_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [ADDR_W-1:0]    granted_address_o,
  output logic                 pool_valid_o,
  output logic [CNT_W-1:0]     free_count_o
);

  cmd_t cmd;
  sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  fbpa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (mode_i),
    .block_address_i   (block_address_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .pool_valid_o      (pool_valid_o),
    .free_count_o      (free_count_o)
  );

endmodule

// ===== hw/rtl/fbpa_ctrl.sv =====
// Controller state machine: decodes each request and sequences the datapath.
`timescale 1ns / 1ps
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d        = S_IDLE;
        cmd_o.res_load = 1'b1;
        unique case (sts_i.mode)
          MODE_INIT: begin
            if (sts_i.init_bad) begin
              cmd_o.res_status = ST_INVALID;
            end else begin
              cmd_o.res_load   = 1'b0;
              cmd_o.fill_start = 1'b1;
              state_d          = S_FILL;
            end
          end
          MODE_ALLOC: begin
            priority if (!sts_i.pool_valid) begin
              cmd_o.res_status = ST_INVALID;
            end else if (sts_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.res_load   = 1'b0;
              cmd_o.alloc_read = 1'b1;
              state_d          = S_GRANT;
            end
          end
          MODE_FREE: begin
            priority if (!sts_i.pool_valid || sts_i.addr_zero) begin
              cmd_o.res_status = ST_INVALID;
            end else if (sts_i.full) begin
              cmd_o.res_status = ST_OVERFLOW;
            end else begin
              cmd_o.free_push  = 1'b1;
              cmd_o.res_status = ST_OK;
            end
          end
          default: begin
            cmd_o.res_status = ST_INVALID;
          end
        endcase
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.fill_done  = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_GRANT: begin
        cmd_o.alloc_pop  = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/fbpa_dp.sv =====
// Datapath: settings, free-list memory, FIFO pointers, fill generator, result registers.
`timescale 1ns / 1ps
module fbpa_dp import fbpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  input  logic [1:0]           mode_i,
  input  logic [ADDR_W-1:0]    block_address_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [ADDR_W-1:0]    granted_address_o,
  output logic                 pool_valid_o,
  output logic [CNT_W-1:0]     free_count_o
);

  // settings
  logic [ADDR_W-1:0] base_q;
  logic [BSZ_W-1:0]  bsize_q;
  logic [CNT_W-1:0]  bcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      bsize_q  <= BSZ_RESET;
      bcount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REGION_BASE: base_q   <= cfg_wdata_i;
        CFG_BLOCK_SIZE:  bsize_q  <= cfg_wdata_i[BSZ_W-1:0];
        CFG_BLOCK_COUNT: bcount_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [1:0]        mode_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      addr_q <= block_address_i;
    end
  end

  // FIFO control state
  logic [PTR_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] count_q;
  logic             valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      priority if (cmd_i.fill_done) begin
        head_q  <= '0;
        tail_q  <= bcount_q[PTR_W-1:0];
        count_q <= bcount_q;
        valid_q <= 1'b1;
      end else if (cmd_i.alloc_pop) begin
        head_q  <= head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end else if (cmd_i.free_push) begin
        tail_q  <= tail_q + 1'b1;
        count_q <= count_q + 1'b1;
      end
    end
  end

  // fill address generator
  logic [ADDR_W-1:0] acc_q;
  logic [CNT_W-1:0]  fill_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_start) begin
      acc_q      <= base_q + HEADER_OFS;
      fill_idx_q <= '0;
    end else if (cmd_i.fill_step) begin
      acc_q      <= acc_q + ADDR_W'(bsize_q);
      fill_idx_q <= fill_idx_q + 1'b1;
    end
  end

  // free-list memory
  logic [ADDR_W-1:0] mem [POOL_DEPTH];
  logic [ADDR_W-1:0] rdata_q;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0] mem_wdata;

  assign mem_we    = cmd_i.fill_step | cmd_i.free_push;
  assign mem_waddr = cmd_i.fill_step ? fill_idx_q[PTR_W-1:0] : tail_q;
  assign mem_wdata = cmd_i.fill_step ? acc_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_read) begin
      rdata_q <= mem[head_q];
    end
  end

  // result registers
  logic              done_q;
  logic [1:0]        status_q;
  logic [ADDR_W-1:0] grant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      grant_q  <= cmd_i.alloc_pop ? rdata_q : '0;
    end
  end

  assign sts_o.mode       = mode_e'(mode_q);
  assign sts_o.init_bad   = (base_q == '0) || (bcount_q == '0) ||
                            (bsize_q < MIN_BSZ) || (bcount_q > POOL_CNT_MAX);
  assign sts_o.pool_valid = valid_q;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q >= POOL_CNT_MAX);
  assign sts_o.addr_zero  = (addr_q == '0);
  assign sts_o.fill_last  = (fill_idx_q == bcount_q - 1'b1);

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign granted_address_o = grant_q;
  assign pool_valid_o      = valid_q;
  assign free_count_o      = count_q;

endmodule
